FILE: rtl/rate_monotonic_tick_scheduler_core_assert.svh
// Assertion macros shared by the scheduler RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_CORE_ASSERT_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RMTS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMTS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rmts_pkg.sv
`timescale 1ns / 1ps

package rmts_pkg;

  // Register file layout: four periods followed by four compute times.
  localparam int MAX_PERIODIC   = 4;
  localparam int MAX_APERIODIC  = 8;
  localparam int REG_FIRST_COMP = 4;
  localparam logic [15:0] PERIOD_RESET = 16'd100;

  // Codes for what ran during a tick.
  localparam logic [1:0] KIND_IDLE      = 2'd0;
  localparam logic [1:0] KIND_PERIODIC  = 2'd1;
  localparam logic [1:0] KIND_APERIODIC = 2'd2;

  typedef struct packed {
    logic [MAX_PERIODIC-1:0][15:0] period;
    logic [MAX_PERIODIC-1:0][15:0] comp_time;
  } rmts_cfg_t;

  typedef struct packed {
    logic        aper_release;
    logic [2:0]  aper_slot;
    logic [15:0] aper_comp_time;
  } rmts_item_t;

  typedef struct packed {
    logic [1:0]  run_kind;
    logic [2:0]  run_task;
    logic        preempted;
    logic [3:0]  periodic_miss_mask;
    logic [7:0]  aperiodic_miss_mask;
    logic        aper_done;
    logic [15:0] aper_response;
    logic [15:0] total_preemptions;
    logic [15:0] total_misses;
  } rmts_result_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

endpackage

FILE: rtl/rmts_cfg_regs.sv
`timescale 1ns / 1ps

module rmts_cfg_regs
  import rmts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output rmts_cfg_t   cfg
);

  logic [2:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PERIODIC; i++) begin
        cfg.period[i]    <= PERIOD_RESET;
        cfg.comp_time[i] <= '0;
      end
    end else if (wr_en) begin
      if (reg_index < 3'(REG_FIRST_COMP)) begin
        cfg.period[reg_index[1:0]] <= pwdata[15:0];
      end else begin
        cfg.comp_time[reg_index[1:0]] <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (reg_index < 3'(REG_FIRST_COMP)) begin
      prdata = {16'd0, cfg.period[reg_index[1:0]]};
    end else begin
      prdata = {16'd0, cfg.comp_time[reg_index[1:0]]};
    end
  end

endmodule

FILE: rtl/rmts_step.sv
`timescale 1ns / 1ps

module rmts_step
  import rmts_pkg::*;
#(
  parameter int NUM_PERIODIC  = 4,
  parameter int NUM_APERIODIC = 8,
  parameter int APER_DEADLINE = 500
) (
  input  rmts_item_t                         item,
  input  rmts_cfg_t                          cfg,
  input  logic [31:0]                        cur_time,
  input  logic [NUM_PERIODIC-1:0][15:0]      per_rem,
  input  logic [NUM_PERIODIC-1:0][31:0]      per_next,
  input  logic [NUM_PERIODIC-1:0][31:0]      per_last,
  input  logic [NUM_APERIODIC-1:0][15:0]     aper_rem,
  input  logic [NUM_APERIODIC-1:0][31:0]     aper_dl,
  input  logic [NUM_APERIODIC-1:0][31:0]     aper_rt,
  input  logic [NUM_APERIODIC-1:0]           aper_rel,
  input  logic [1:0]                         running_kind,
  input  logic [2:0]                         running_index,
  input  logic [15:0]                        preempt_total,
  input  logic [15:0]                        miss_total,
  output logic [31:0]                        cur_time_next,
  output logic [NUM_PERIODIC-1:0][15:0]      per_rem_next,
  output logic [NUM_PERIODIC-1:0][31:0]      per_next_next,
  output logic [NUM_PERIODIC-1:0][31:0]      per_last_next,
  output logic [NUM_APERIODIC-1:0][15:0]     aper_rem_next,
  output logic [NUM_APERIODIC-1:0][31:0]     aper_dl_next,
  output logic [NUM_APERIODIC-1:0][31:0]     aper_rt_next,
  output logic [NUM_APERIODIC-1:0]           aper_rel_next,
  output rmts_result_t                       res
);

  logic [31:0] t;
  logic [3:0]  nmiss;
  logic        found_p;
  logic        found_a;
  logic [2:0]  sel_p;
  logic [2:0]  sel_a;
  logic [15:0] best_period;
  logic [15:0] cur_p_rem;
  logic [31:0] cur_p_last;
  logic [15:0] cur_a_rem;
  logic [31:0] age;
  logic [16:0] miss_sum;

  assign t = cur_time;

  always_comb begin
    res         = '0;
    nmiss       = '0;
    found_p     = 1'b0;
    found_a     = 1'b0;
    sel_p       = '0;
    sel_a       = '0;
    best_period = '0;
    cur_p_rem   = '0;
    cur_p_last  = '0;
    cur_a_rem   = '0;
    age         = '0;

    // Periodic releases: work left over at a release is a miss.
    for (int i = 0; i < NUM_PERIODIC; i++) begin
      per_rem_next[i]  = per_rem[i];
      per_next_next[i] = per_next[i];
      per_last_next[i] = per_last[i];
      if (t == per_next[i]) begin
        if (per_rem[i] != '0) begin
          res.periodic_miss_mask[i] = 1'b1;
          nmiss = nmiss + 4'd1;
        end
        per_rem_next[i]  = cfg.comp_time[i];
        per_last_next[i] = t;
        per_next_next[i] = sat_add32(t, {16'd0, cfg.period[i]});
      end
    end

    // Aperiodic drops past the deadline, then the release from the request.
    for (int i = 0; i < NUM_APERIODIC; i++) begin
      aper_rem_next[i] = aper_rem[i];
      aper_dl_next[i]  = aper_dl[i];
      aper_rt_next[i]  = aper_rt[i];
      aper_rel_next[i] = aper_rel[i];
      if (t > aper_dl[i] && aper_rem[i] != '0) begin
        res.aperiodic_miss_mask[i] = 1'b1;
        nmiss = nmiss + 4'd1;
        aper_rem_next[i] = '0;
      end
      if (item.aper_release && item.aper_slot == 3'(i)) begin
        aper_rem_next[i] = item.aper_comp_time;
        aper_dl_next[i]  = sat_add32(t, 32'(APER_DEADLINE));
        aper_rt_next[i]  = t;
        aper_rel_next[i] = 1'b1;
      end
    end

    // Shortest period wins; strict compare keeps ties on the lower index.
    for (int i = 0; i < NUM_PERIODIC; i++) begin
      if (per_rem_next[i] != '0 && (!found_p || cfg.period[i] < best_period)) begin
        found_p     = 1'b1;
        sel_p       = 3'(i);
        best_period = cfg.period[i];
      end
    end
    for (int i = 0; i < NUM_APERIODIC; i++) begin
      if (!found_a && aper_rel_next[i] && aper_rem_next[i] != '0) begin
        found_a = 1'b1;
        sel_a   = 3'(i);
      end
    end

    // State of whatever ran last tick, after releases and drops.
    for (int i = 0; i < NUM_PERIODIC; i++) begin
      if (running_index == 3'(i)) begin
        cur_p_rem  = per_rem_next[i];
        cur_p_last = per_last_next[i];
      end
    end
    for (int i = 0; i < NUM_APERIODIC; i++) begin
      if (running_index == 3'(i)) begin
        cur_a_rem = aper_rem_next[i];
      end
    end
    if (running_kind == KIND_PERIODIC) begin
      res.preempted = (!found_p || sel_p != running_index) && cur_p_rem != '0 &&
                      cur_p_last != t;
    end else if (running_kind == KIND_APERIODIC) begin
      res.preempted = found_p && cur_a_rem != '0;
    end

    // One tick of work for the selected task or job.
    if (found_p) begin
      res.run_kind = KIND_PERIODIC;
      res.run_task = sel_p;
      for (int i = 0; i < NUM_PERIODIC; i++) begin
        if (sel_p == 3'(i)) begin
          per_rem_next[i] = per_rem_next[i] - 16'd1;
        end
      end
    end else if (found_a) begin
      res.run_kind = KIND_APERIODIC;
      res.run_task = sel_a;
      for (int i = 0; i < NUM_APERIODIC; i++) begin
        if (sel_a == 3'(i)) begin
          if (aper_rem_next[i] == 16'd1) begin
            res.aper_done = 1'b1;
            age = t - aper_rt_next[i];
          end
          aper_rem_next[i] = aper_rem_next[i] - 16'd1;
        end
      end
      res.aper_response = (age > 32'h0000_FFFF) ? 16'hFFFF : age[15:0];
    end

    res.total_preemptions = (res.preempted && preempt_total != 16'hFFFF) ?
                            preempt_total + 16'd1 : preempt_total;
    miss_sum = {1'b0, miss_total} + {13'd0, nmiss};
    res.total_misses = miss_sum[16] ? 16'hFFFF : miss_sum[15:0];
  end

  assign cur_time_next = sat_add32(t, 32'd1);

endmodule

FILE: rtl/rate_monotonic_tick_scheduler_core.sv
`timescale 1ns / 1ps

// Rate-monotonic tick scheduler. Every request on the slave stream is one time
// tick and may also release an aperiodic job into a slot; every tick yields
// exactly one result on the master stream, saying what ran (idle, a periodic
// task or an aperiodic job), whether earlier work was preempted, which tasks
// and slots missed their deadlines, any aperiodic completion with its
// response time, and saturating totals of preemptions and misses. Periodic
// tasks are set up through the APB port (periods at 0x00..0x0C, compute times
// at 0x10..0x1C; a compute time of zero disables a task) and the port should
// only be written while no tick is in flight. Throughput is one tick per
// clock while m_tready does not stall: the whole tick update is a single
// pass of combinational logic between the input register and the result
// register, so the rate is set by that one stage. No clearing pass is
// needed after reset; all scheduler state is held in flip-flops.

`include "rate_monotonic_tick_scheduler_core_assert.svh"

module rate_monotonic_tick_scheduler_core
  import rmts_pkg::*;
#(
  parameter int NUM_PERIODIC  = 4,
  parameter int NUM_APERIODIC = 8,
  parameter int APER_DEADLINE = 500
) (
  input  logic        clk,
  input  logic        rst,
  // Tick requests.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // aper_slot[2:0], aper_comp_time[18:3], zero pad
  input  logic        s_tuser,   // aper_release
  // Tick results.
  output logic        m_tvalid,
  input  logic        m_tready,
  // run_task[2:0], preempted[3], periodic_miss_mask[7:4],
  // aperiodic_miss_mask[15:8], aper_done[16], aper_response[32:17],
  // total_preemptions[48:33], total_misses[64:49], zero pad
  output logic [71:0] m_tdata,
  output logic [1:0]  m_tuser,   // run_kind
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rmts_cfg_t    cfg;
  rmts_item_t   in_item;
  logic         in_valid;
  logic         out_valid;
  rmts_result_t out_res;
  rmts_result_t step_res;
  logic         advance;

  // Scheduler state.
  logic [31:0]                     cur_time;
  logic [NUM_PERIODIC-1:0][15:0]   per_rem;
  logic [NUM_PERIODIC-1:0][31:0]   per_next;
  logic [NUM_PERIODIC-1:0][31:0]   per_last;
  logic [NUM_APERIODIC-1:0][15:0]  aper_rem;
  logic [NUM_APERIODIC-1:0][31:0]  aper_dl;
  logic [NUM_APERIODIC-1:0][31:0]  aper_rt;
  logic [NUM_APERIODIC-1:0]        aper_rel;
  logic [1:0]                      running_kind;
  logic [2:0]                      running_index;
  logic [15:0]                     preempt_total;
  logic [15:0]                     miss_total;

  logic [31:0]                     cur_time_next;
  logic [NUM_PERIODIC-1:0][15:0]   per_rem_next;
  logic [NUM_PERIODIC-1:0][31:0]   per_next_next;
  logic [NUM_PERIODIC-1:0][31:0]   per_last_next;
  logic [NUM_APERIODIC-1:0][15:0]  aper_rem_next;
  logic [NUM_APERIODIC-1:0][31:0]  aper_dl_next;
  logic [NUM_APERIODIC-1:0][31:0]  aper_rt_next;
  logic [NUM_APERIODIC-1:0]        aper_rel_next;

  rmts_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held tick moves into the result register whenever that register is
  // empty or its contents are being taken this cycle; while a finished result
  // waits, the input side can still fill its own register, then stalls.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.aper_release   <= s_tuser;
      in_item.aper_slot      <= s_tdata[2:0];
      in_item.aper_comp_time <= s_tdata[18:3];
    end
  end

  rmts_step #(
    .NUM_PERIODIC  (NUM_PERIODIC),
    .NUM_APERIODIC (NUM_APERIODIC),
    .APER_DEADLINE (APER_DEADLINE)
  ) u_step (
    .item          (in_item),
    .cfg           (cfg),
    .cur_time      (cur_time),
    .per_rem       (per_rem),
    .per_next      (per_next),
    .per_last      (per_last),
    .aper_rem      (aper_rem),
    .aper_dl       (aper_dl),
    .aper_rt       (aper_rt),
    .aper_rel      (aper_rel),
    .running_kind  (running_kind),
    .running_index (running_index),
    .preempt_total (preempt_total),
    .miss_total    (miss_total),
    .cur_time_next (cur_time_next),
    .per_rem_next  (per_rem_next),
    .per_next_next (per_next_next),
    .per_last_next (per_last_next),
    .aper_rem_next (aper_rem_next),
    .aper_dl_next  (aper_dl_next),
    .aper_rt_next  (aper_rt_next),
    .aper_rel_next (aper_rel_next),
    .res           (step_res)
  );

  // State commits only when a tick is handed to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time      <= '0;
      per_rem       <= '0;
      per_next      <= '0;
      per_last      <= '1;
      aper_rem      <= '0;
      aper_dl       <= '0;
      aper_rt       <= '0;
      aper_rel      <= '0;
      running_kind  <= KIND_IDLE;
      running_index <= '0;
      preempt_total <= '0;
      miss_total    <= '0;
    end else if (advance) begin
      cur_time      <= cur_time_next;
      per_rem       <= per_rem_next;
      per_next      <= per_next_next;
      per_last      <= per_last_next;
      aper_rem      <= aper_rem_next;
      aper_dl       <= aper_dl_next;
      aper_rt       <= aper_rt_next;
      aper_rel      <= aper_rel_next;
      running_kind  <= step_res.run_kind;
      running_index <= step_res.run_task;
      preempt_total <= step_res.total_preemptions;
      miss_total    <= step_res.total_misses;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.run_kind;
  assign m_tdata  = {7'd0,
                     out_res.total_misses,
                     out_res.total_preemptions,
                     out_res.aper_response,
                     out_res.aper_done,
                     out_res.aperiodic_miss_mask,
                     out_res.periodic_miss_mask,
                     out_res.preempted,
                     out_res.run_task};

  // An aperiodic completion can only be reported for a tick that ran one.
  `RMTS_ASSERT_NOW(a_done_is_aperiodic, out_valid && out_res.aper_done, out_res.run_kind == KIND_APERIODIC, "aper_done without an aperiodic run")

  // The response time is zero unless a completion is reported.
  `RMTS_ASSERT_NOW(a_response_only_on_done, out_valid && !out_res.aper_done, out_res.aper_response == 16'd0, "aper_response set without aper_done")

  // The preemption total moves only on a tick that reports a preemption.
  `RMTS_ASSERT_NEXT(a_preempt_total_hold, !advance || !step_res.preempted, preempt_total == $past(preempt_total), "preemption total changed without a preemption")

  // The miss total never decreases.
  `RMTS_ASSERT_NEXT(a_miss_total_monotone, advance, miss_total >= $past(miss_total), "miss total decreased")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

// Stand-alone bench for the rate-monotonic tick scheduler. Every request on
// the slave stream is one tick; a behavioural copy of the scheduler runs here
// alongside the block and predicts the single result that each accepted
// request produces. Results are compared field by field, in order, as they
// leave the master stream.
module tb_top;
  import rmts_pkg::*;

  // The block is built with its default sizes; the aperiodic deadline is
  // passed explicitly so that the bench and the block agree on it.
  localparam int APER_WINDOW      = 500;
  localparam int REG_FIRST_PERIOD = 0;
  localparam int RANDOM_ROUNDS    = 5;
  localparam int ROUND_TICKS      = 150;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int LOAD_TICKS       = 40;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // aper_slot[2:0], aper_comp_time[18:3], zero pad
  logic        s_tuser;   // aper_release
  logic        m_tvalid;
  logic        m_tready;
  // run_task[2:0], preempted[3], periodic_miss_mask[7:4],
  // aperiodic_miss_mask[15:8], aper_done[16], aper_response[32:17],
  // total_preemptions[48:33], total_misses[64:49], zero pad
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;   // run_kind
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rate_monotonic_tick_scheduler_core #(
    .NUM_PERIODIC (MAX_PERIODIC),
    .NUM_APERIODIC(MAX_APERIODIC),
    .APER_DEADLINE(APER_WINDOW)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Scheduler copy. The shadow registers follow every APB write, and the
  // state below mirrors the block's own tick state.
  // ---------------------------------------------------------------------
  logic [15:0] cfg_period [MAX_PERIODIC];
  logic [15:0] cfg_comp   [MAX_PERIODIC];

  logic [31:0] now_tick;
  logic [15:0] task_left  [MAX_PERIODIC];
  logic [31:0] task_next  [MAX_PERIODIC];
  logic [31:0] task_last  [MAX_PERIODIC];
  logic [15:0] job_left   [MAX_APERIODIC];
  logic [31:0] job_due    [MAX_APERIODIC];
  logic [31:0] job_start  [MAX_APERIODIC];
  logic        job_live   [MAX_APERIODIC];
  logic [1:0]  last_kind;
  logic [2:0]  last_idx;
  logic [15:0] preempt_sum;
  logic [15:0] miss_sum;

  // Results still owed by the block, oldest first.
  rmts_result_t tick_reports[$];

  int mismatches;
  int result_count;
  int idle_cycles;
  // Chance in percent that the sender pauses before a request, and that the
  // receiver stalls at a given falling edge. Both are zero in the last part.
  int gap_pct;
  int stall_pct;

  function automatic void scheduler_reset();
    for (int i = 0; i < MAX_PERIODIC; i++) begin
      cfg_period[i] = PERIOD_RESET;
      cfg_comp[i]   = '0;
      task_left[i]  = '0;
      task_next[i]  = '0;
      task_last[i]  = '1;
    end
    for (int j = 0; j < MAX_APERIODIC; j++) begin
      job_left[j]  = '0;
      job_due[j]   = '0;
      job_start[j] = '0;
      job_live[j]  = 1'b0;
    end
    now_tick    = '0;
    last_kind   = KIND_IDLE;
    last_idx    = '0;
    preempt_sum = '0;
    miss_sum    = '0;
  endfunction

  // Advances the copy by one tick and returns what the block should report.
  function automatic rmts_result_t schedule_tick(input rmts_item_t req);
    rmts_result_t r;
    logic [32:0]  sum;
    logic [31:0]  t;
    logic [31:0]  span;
    logic [16:0]  tally;
    logic         preempt;
    int           sel_p;
    int           sel_a;
    int           n_miss;
    r       = '0;
    t       = now_tick;
    sel_p   = -1;
    sel_a   = -1;
    n_miss  = 0;
    preempt = 1'b0;

    // Periodic releases: leftover work is a miss, then the budget reloads.
    for (int i = 0; i < MAX_PERIODIC; i++) begin
      if (t == task_next[i]) begin
        if (task_left[i] != 0) begin
          r.periodic_miss_mask[i] = 1'b1;
          n_miss++;
        end
        task_left[i] = cfg_comp[i];
        task_last[i] = t;
        sum = {1'b0, t} + 33'(cfg_period[i]);
        task_next[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
    end

    // Aperiodic jobs still holding work past their deadline are dropped.
    for (int j = 0; j < MAX_APERIODIC; j++) begin
      if (t > job_due[j] && job_left[j] != 0) begin
        r.aperiodic_miss_mask[j] = 1'b1;
        n_miss++;
        job_left[j] = '0;
      end
    end

    // A release into a busy slot simply replaces the old job.
    if (req.aper_release) begin
      job_left[req.aper_slot]  = req.aper_comp_time;
      sum = {1'b0, t} + 33'(APER_WINDOW);
      job_due[req.aper_slot]   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      job_start[req.aper_slot] = t;
      job_live[req.aper_slot]  = 1'b1;
    end

    // Shortest period wins; a strict compare leaves ties with the lower index.
    for (int i = 0; i < MAX_PERIODIC; i++) begin
      if (task_left[i] != 0 && (sel_p < 0 || cfg_period[i] < cfg_period[sel_p]))
        sel_p = i;
    end
    if (sel_p < 0) begin
      for (int j = MAX_APERIODIC - 1; j >= 0; j--) begin
        if (job_live[j] && job_left[j] != 0)
          sel_a = j;
      end
    end

    // A periodic task just released is not counted as preempted, and one
    // aperiodic job displacing another is not a preemption either.
    if (last_kind == KIND_PERIODIC) begin
      if (sel_p != int'(last_idx) && task_left[last_idx[1:0]] != 0 &&
          task_last[last_idx[1:0]] != t)
        preempt = 1'b1;
    end else if (last_kind == KIND_APERIODIC && sel_p >= 0) begin
      if (job_left[last_idx] != 0)
        preempt = 1'b1;
    end

    if (sel_p >= 0) begin
      task_left[sel_p]--;
      r.run_kind = KIND_PERIODIC;
      r.run_task = 3'(sel_p);
    end else if (sel_a >= 0) begin
      job_left[sel_a]--;
      r.run_kind = KIND_APERIODIC;
      r.run_task = 3'(sel_a);
      if (job_left[sel_a] == 0) begin
        span = t - job_start[sel_a];
        r.aper_done     = 1'b1;
        r.aper_response = (span > 32'h0000_FFFF) ? 16'hFFFF : span[15:0];
      end
    end
    last_kind = r.run_kind;
    last_idx  = r.run_task;

    if (preempt && preempt_sum != 16'hFFFF)
      preempt_sum++;
    tally = {1'b0, miss_sum} + 17'(n_miss);
    miss_sum = tally[16] ? 16'hFFFF : tally[15:0];
    if (now_tick != 32'hFFFF_FFFF)
      now_tick++;

    r.preempted         = preempt;
    r.total_preemptions = preempt_sum;
    r.total_misses      = miss_sum;
    return r;
  endfunction

  function automatic string show(input rmts_result_t r);
    return $sformatf({"kind=%0d task=%0d pre=%0b pmiss=%h amiss=%h done=%0b ",
                      "resp=%0d npre=%0d nmiss=%0d"},
                     r.run_kind, r.run_task, r.preempted, r.periodic_miss_mask,
                     r.aperiodic_miss_mask, r.aper_done, r.aper_response,
                     r.total_preemptions, r.total_misses);
  endfunction

  // Only the first ten failures are described; the rest are just counted.
  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("%s", what);
  endfunction

  // ---------------------------------------------------------------------
  // Result checking, sampled at the rising edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    rmts_result_t got;
    rmts_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.run_kind            = m_tuser;
      got.run_task            = m_tdata[2:0];
      got.preempted           = m_tdata[3];
      got.periodic_miss_mask  = m_tdata[7:4];
      got.aperiodic_miss_mask = m_tdata[15:8];
      got.aper_done           = m_tdata[16];
      got.aper_response       = m_tdata[32:17];
      got.total_preemptions   = m_tdata[48:33];
      got.total_misses        = m_tdata[64:49];
      if (tick_reports.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing owed: %s",
                                result_count, show(got)));
      end else begin
        want = tick_reports.pop_front();
        if (got !== want)
          note_mismatch($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                                  result_count, show(want), show(got)));
      end
      result_count++;
    end
  end

  // The watchdog only counts cycles in which neither stream moves a request.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stalls come in bursts while stall_pct is set.
  initial begin : result_sink
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(12, 1)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Shared drivers. All of them are entered and left at a falling edge.
  // ---------------------------------------------------------------------

  // Offers one tick request, waits for it to be taken and records the
  // predicted result. tvalid is left high for a following request.
  task automatic send_tick(input logic rel, input logic [2:0] slot,
                           input logic [15:0] work);
    rmts_item_t req;
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= rel;
    s_tdata  <= {5'd0, work, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    req.aper_release   = rel;
    req.aper_slot      = slot;
    req.aper_comp_time = work;
    tick_reports.push_back(schedule_tick(req));
    @(negedge clk);
  endtask

  // Random tick: a release on about one request in four, mostly short jobs,
  // now and then zero work, full work or any 16-bit value.
  task automatic send_random_tick();
    logic [15:0] work;
    case ($urandom_range(15, 0))
      0:       work = '0;
      1:       work = 16'hFFFF;
      2:       work = 16'($urandom_range(65535, 0));
      default: work = 16'($urandom_range(12, 1));
    endcase
    send_tick($urandom_range(3, 0) == 0, 3'($urandom_range(7, 0)), work);
  endtask

  // Holds the sender back until every owed result has arrived. Every tick
  // produces a result, so the owed list empties only once the pipeline drains.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tick_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Optionally writes one register, then reads it back against the shadow.
  task automatic reg_access(input int idx, input logic wr, input logic [15:0] value);
    logic [15:0] shadow;
    if (wr) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 5'(idx * 4);
      pwdata  <= {16'd0, value};
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (idx < REG_FIRST_COMP)
        cfg_period[idx - REG_FIRST_PERIOD] = value;
      else
        cfg_comp[idx - REG_FIRST_COMP] = value;
      @(negedge clk);
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 5'(idx * 4);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow = (idx < REG_FIRST_COMP) ? cfg_period[idx - REG_FIRST_PERIOD]
                                    : cfg_comp[idx - REG_FIRST_COMP];
    if (prdata !== {16'd0, shadow})
      note_mismatch($sformatf("register %0d read back %h, wanted %h",
                              idx, prdata, {16'd0, shadow}));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_task(input int i, input logic [15:0] period, input logic [15:0] comp);
    reg_access(REG_FIRST_PERIOD + i, 1'b1, period);
    reg_access(REG_FIRST_COMP + i, 1'b1, comp);
  endtask

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Every register should read back its reset value before anything is written.
  task automatic test_register_defaults();
    for (int i = 0; i < 2 * MAX_PERIODIC; i++)
      reg_access(i, 1'b0, '0);
  endtask

  // A short hand-written schedule, set up before the first tick so that every
  // task is released at tick zero with the new periods. Tasks 0 and 2 share a
  // period (the tie goes to task 0), task 1 has a longer period and gets
  // preempted at the next release of the faster ones, task 3 is disabled.
  task automatic test_directed_schedule();
    gap_pct   = 0;
    stall_pct = 0;
    set_task(0, 16'd4,     16'd1);
    set_task(1, 16'd6,     16'd3);
    set_task(2, 16'd4,     16'd2);
    set_task(3, 16'hFFFF,  16'd0);
    // Slot 5 waits behind the periodic load; slot 7 carries the largest job.
    send_tick(1'b1, 3'd5, 16'd3);
    send_tick(1'b0, 3'd0, 16'd0);
    send_tick(1'b1, 3'd7, 16'hFFFF);
    // A job with no work is released but never runs.
    send_tick(1'b1, 3'd0, 16'd0);
    // Idle ticks: the periodic load leaves no gaps, so the background jobs keep
    // waiting, and task 1 misses its deadline.
    repeat (9) send_tick(1'b0, 3'd0, 16'd0);
    // Slot 5 is released again while still busy, then slot 2 is released too;
    // both jobs keep waiting behind the periodic load.
    send_tick(1'b1, 3'd5, 16'd1);
    send_tick(1'b1, 3'd2, 16'd2);
    repeat (7) send_tick(1'b0, 3'd0, 16'd0);
    settle();
  endtask

  // Task 0 is set to run on every tick, so aperiodic jobs starve and must be
  // dropped once the tick passes their deadline.
  task automatic test_aperiodic_drop();
    gap_pct   = 20;
    stall_pct = 20;
    set_task(0, 16'd1, 16'd1);
    send_tick(1'b1, 3'd4, 16'd10);
    send_tick(1'b1, 3'd6, 16'd600);
    repeat (APER_WINDOW + 8) send_tick(1'b0, 3'($urandom_range(7, 0)), 16'd0);
    settle();
  endtask

  // Rounds of random traffic under changing configurations. The first round
  // uses the smallest periods, the last one the largest values for the
  // lower-priority tasks; the rest are mostly short periods and budgets.
  task automatic test_random_rounds();
    logic [15:0] per;
    logic [15:0] cmp;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      for (int i = 0; i < MAX_PERIODIC; i++) begin
        case (round)
          0: begin
            per = 16'($urandom_range(3, 1));
            cmp = 16'($urandom_range(2, 0));
          end
          RANDOM_ROUNDS - 1: begin
            per = (i < 2) ? 16'($urandom_range(20, 5)) : 16'hFFFF;
            cmp = (i < 2) ? 16'($urandom_range(3, 0))  : 16'hFFFF;
          end
          default: begin
            per = ($urandom_range(7, 0) == 0) ? 16'($urandom_range(65535, 1))
                                              : 16'($urandom_range(40, 2));
            cmp = 16'($urandom_range(6, 0));
          end
        endcase
        set_task(i, per, cmp);
      end
      gap_pct   = (round == 1) ? 0 : $urandom_range(40, 5);
      stall_pct = (round == 2) ? 0 : $urandom_range(40, 5);
      repeat (ROUND_TICKS) send_random_tick();
      settle();
    end
  endtask

  // Keeps both running totals climbing, without idling. First every task gets
  // a budget longer than its period, so it misses at each later release; then
  // task 0 keeps interrupting a long task 1 every other tick.
  task automatic test_heavy_load();
    gap_pct   = 0;
    stall_pct = 0;
    for (int i = 0; i < MAX_PERIODIC; i++)
      set_task(i, 16'd1, 16'd2);
    repeat (LOAD_TICKS) send_random_tick();
    settle();

    set_task(0, 16'd2,    16'd1);
    set_task(1, 16'hFFFF, 16'hFFFF);
    set_task(2, 16'hFFFF, 16'd0);
    set_task(3, 16'hFFFF, 16'd0);
    repeat (LOAD_TICKS) send_random_tick();
  endtask

  // ---------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tuser      = 1'b0;
    s_tdata      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    gap_pct      = 0;
    stall_pct    = 0;
    mismatches   = 0;
    result_count = 0;
    idle_cycles  = 0;
    scheduler_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_defaults();
    test_directed_schedule();
    test_aperiodic_drop();
    test_random_rounds();
    test_heavy_load();

    // Drain: the watchdog bounds this wait if a result never shows up.
    s_tvalid <= 1'b0;
    while (tick_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rmts_pkg.sv
rtl/rmts_cfg_regs.sv
rtl/rmts_step.sv
rtl/rate_monotonic_tick_scheduler_core.sv
tb/tb_top.sv
